>>> hdl/ism_pkg.sv
// Shared types, register codes and constants for the indexed scatter MAC.
// Used by every module of the block; no dependencies of its own.
package ism_pkg;

    // Default sizing of the accumulator table and location range
    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int DEF_MAX_LOCATIONS = 1024;

    // Job address field covers the largest supported table (65536 entries)
    localparam int JOB_ADDR_W = 16;

    // Width of the unreduced address sum: loc-1 + trend*L + column*L*T
    localparam int TL_W   = 15;
    localparam int LT_W   = 16;
    localparam int COLT_W = 22;
    localparam int SUM_W  = 23;

    // Request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Configuration register map
    localparam int          PADDR_W             = 4;
    localparam logic [1:0]  REG_LOCATION_COUNT  = 2'd0;
    localparam logic [1:0]  REG_TREND_COUNT     = 2'd1;
    localparam logic [1:0]  REG_COLUMN_COUNT    = 2'd2;

    // Operation codes
    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    // Saturation bounds of the Q32.32 accumulator
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic               operation;
        logic [10:0]        location;
        logic [3:0]         trend;
        logic [5:0]         column;
        logic signed [31:0] trend_value;
        logic signed [31:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] entry_value;
        logic               range_error;
    } t_out_item;

    typedef struct packed {
        logic [10:0] location_count;
        logic [4:0]  trend_count;
        logic [6:0]  column_count;
    } t_cfg;

    // Classified request handed from front to back
    typedef struct packed {
        logic                  op;
        logic                  err;
        logic [JOB_ADDR_W-1:0] addr;
        logic signed [63:0]    prod;
    } t_job;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RMW
    } t_back_state;

endpackage

>>> hdl/ism_front.sv
// Front end: accepts requests, multiplies the Q16.16 operands, computes the
// table address and range flags, and pushes a job into the queue. Uses ism_pkg.
module ism_front #(
    parameter int TABLE_ENTRIES = ism_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_LOCATIONS = ism_pkg::DEF_MAX_LOCATIONS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ism_pkg::t_cfg     i_cfg,
    input  logic              i_clearing,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ism_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output ism_pkg::t_job     o_push_data
);
    import ism_pkg::*;

    // Stage 1: captured request
    logic     r_s1_valid;
    t_in_item r_s1_item;

    // Stage 2: partial address terms, flags and product
    logic                  r_s2_valid;
    logic                  r_s2_op;
    logic                  r_s2_err;
    logic [10:0]           r_s2_loc_m1;
    logic [TL_W-1:0]       r_s2_tl;
    logic [LT_W-1:0]       r_s2_lt;
    logic [5:0]            r_s2_column;
    logic signed [63:0]    r_s2_prod;

    logic                  w_accept;
    logic                  w_s2_load;
    logic                  w_s1_err;
    logic [TL_W-1:0]       w_tl;
    logic [LT_W-1:0]       w_lt;
    logic signed [63:0]    w_prod;
    logic [COLT_W-1:0]     w_col_term;
    logic [SUM_W-1:0]      w_sum;
    logic                  w_addr_err;

    // Handshake: stage 2 drains into the queue, stage 1 into stage 2
    assign o_push     = r_s2_valid && !i_q_full;
    assign w_s2_load  = !r_s2_valid || o_push;
    assign o_in_stall = i_clearing || (r_s1_valid && !w_s2_load);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Stage 1 logic: index range checks, the small multiplies and the product
    assign w_s1_err = (r_s1_item.location == 11'd0)
                   || (r_s1_item.location > i_cfg.location_count)
                   || (32'(r_s1_item.location) > 32'(MAX_LOCATIONS))
                   || (5'(r_s1_item.trend) >= i_cfg.trend_count)
                   || (7'(r_s1_item.column) >= i_cfg.column_count);
    assign w_tl   = TL_W'(r_s1_item.trend) * TL_W'(i_cfg.location_count);
    assign w_lt   = LT_W'(i_cfg.location_count) * LT_W'(i_cfg.trend_count);
    assign w_prod = 64'($signed(r_s1_item.trend_value))
                  * 64'($signed(r_s1_item.data_value));

    // Stage 2 logic: final address sum and table bound
    assign w_col_term = COLT_W'(r_s2_column) * COLT_W'(r_s2_lt);
    assign w_sum      = SUM_W'(r_s2_loc_m1) + SUM_W'(r_s2_tl) + SUM_W'(w_col_term);
    assign w_addr_err = 32'(w_sum) >= 32'(TABLE_ENTRIES);

    always_comb begin
        o_push_data      = '0;
        o_push_data.op   = r_s2_op;
        o_push_data.err  = r_s2_err || w_addr_err;
        o_push_data.addr = w_sum[JOB_ADDR_W-1:0];
        o_push_data.prod = r_s2_prod;
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item <= i_in_data;
        end
        if (w_s2_load) begin
            r_s2_op     <= r_s1_item.operation;
            r_s2_err    <= w_s1_err;
            r_s2_loc_m1 <= r_s1_item.location - 11'd1;
            r_s2_tl     <= w_tl;
            r_s2_lt     <= w_lt;
            r_s2_column <= r_s1_item.column;
            r_s2_prod   <= w_prod;
        end
    end

endmodule

>>> hdl/ism_queue.sv
// Small job queue that decouples the front end from the accumulator back end.
// Uses ism_pkg for the job type and depth.
module ism_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ism_pkg::t_job i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output ism_pkg::t_job o_head,
    output logic          o_empty
);
    import ism_pkg::*;

    t_job               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> hdl/ism_back.sv
// Back end: read-modify-write of the accumulator memory, clearing pass after
// reset, and the result register. Uses ism_pkg.
module ism_back #(
    parameter int TABLE_ENTRIES = ism_pkg::DEF_TABLE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  ism_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ism_pkg::t_out_item o_out_data
);
    import ism_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [63:0]        r_acc_mem [TABLE_ENTRIES];

    t_back_state        r_state;
    t_back_state        n_state;
    logic [AW-1:0]      r_clr_addr;
    t_job               r_job;
    logic signed [63:0] r_rd_data;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               w_out_free;
    logic               w_rd_en;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [63:0]        w_wr_data;
    logic               w_load_out;
    logic signed [63:0] w_sum;
    logic               w_ovf;
    logic signed [63:0] w_acc_value;
    t_out_item          w_result;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Saturating Q32.32 add of the stored entry and the product
    assign w_sum = r_rd_data + r_job.prod;
    assign w_ovf = (r_rd_data[63] == r_job.prod[63]) && (w_sum[63] != r_rd_data[63]);
    assign w_acc_value = w_ovf ? (r_rd_data[63] ? ACC_MIN : ACC_MAX) : w_sum;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == AW'(TABLE_ENTRIES - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_empty && w_out_free) begin
                    n_state = BK_RMW;
                end
            end
            BK_RMW:  n_state = BK_IDLE;
            default: n_state = BK_CLEAR;
        endcase
    end

    // State outputs: memory ports, queue pop, result load
    always_comb begin
        o_clearing = 1'b0;
        o_pop      = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_job.addr[AW-1:0];
        w_wr_data  = '0;
        w_load_out = 1'b0;
        w_result   = '0;
        case (r_state)
            BK_CLEAR: begin
                o_clearing = 1'b1;
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
            end
            BK_IDLE: begin
                o_pop   = !i_q_empty && w_out_free;
                w_rd_en = o_pop;
            end
            BK_RMW: begin
                w_load_out = 1'b1;
                w_wr_en    = !r_job.err;
                if (r_job.err) begin
                    w_result.range_error = 1'b1;
                end else if (r_job.op == OP_READ) begin
                    w_result.entry_value = r_rd_data;
                end else begin
                    w_result.entry_value = w_acc_value;
                    w_wr_data            = w_acc_value;
                end
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (w_load_out) begin
            r_out_data <= w_result;
        end
    end

    // Accumulator memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_acc_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= $signed(r_acc_mem[i_head.addr[AW-1:0]]);
        end
    end

endmodule

>>> hdl/indexed_scatter_mac_top.sv
// Indexed scatter MAC: accumulates Q16.16 products into a Q32.32 table, reads and clears.
// Request path: front stage 1, front stage 2, job queue, table read, result register.
// Requests queue up while the table memory does its read-modify-writes.
// Reset: counts return to 1; the table is zeroed by a pass over all TABLE_ENTRIES entries,
// during which requests are stalled (configuration writes are still taken).
// Depends on ism_pkg, ism_front, ism_queue and ism_back.
module indexed_scatter_mac_top #(
    parameter int TABLE_ENTRIES = ism_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_LOCATIONS = ism_pkg::DEF_MAX_LOCATIONS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ism_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ism_pkg::t_out_item           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ism_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ism_pkg::*;

    t_cfg  r_cfg;
    logic  w_cfg_wr;
    logic  w_clearing;
    logic  w_push;
    t_job  w_push_data;
    logic  w_q_full;
    logic  w_q_empty;
    logic  w_pop;
    t_job  w_head;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.location_count <= 11'd1;
            r_cfg.trend_count    <= 5'd1;
            r_cfg.column_count   <= 7'd1;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_LOCATION_COUNT: r_cfg.location_count <= pwdata[10:0];
                REG_TREND_COUNT:    r_cfg.trend_count    <= pwdata[4:0];
                REG_COLUMN_COUNT:   r_cfg.column_count   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LOCATION_COUNT: prdata = 32'(r_cfg.location_count);
            REG_TREND_COUNT:    prdata = 32'(r_cfg.trend_count);
            REG_COLUMN_COUNT:   prdata = 32'(r_cfg.column_count);
            default:            prdata = '0;
        endcase
    end

    ism_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_LOCATIONS (MAX_LOCATIONS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_clearing  (w_clearing),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    ism_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_empty     (w_q_empty)
    );

    ism_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // No request gets in while the table is being zeroed
    a_stall_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_in_stall)
        else $error("request path open during table clearing pass");

    // Queue is never pushed when full nor popped when empty
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((w_push && w_q_full) || (w_pop && w_q_empty)))
        else $error("job queue overflow or underflow");

    // The clearing pass runs once, right after reset
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$rose(w_clearing))
        else $error("clearing pass restarted outside reset");

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for indexed_scatter_mac_top: directed table, then randomized phases.
// Needs ism_pkg and the RTL; predicts random results from its own model of the Q32.32 table.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ism_pkg::*;

    // One row of the directed table: either a count register write or a request
    typedef struct {
        bit                 is_cfg;
        logic [1:0]         reg_idx;
        int unsigned        count;
        t_in_item           req;
        logic signed [63:0] want_value;
        bit                 want_err;
    } t_step;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] Q_NEG_ONE = -32'sh0001_0000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow of the block: accumulator table and count registers
    longint      acc_table [DEF_TABLE_ENTRIES];
    bit [10:0]   loc_cnt = 11'd1;
    bit [4:0]    trend_cnt = 5'd1;
    bit [6:0]    col_cnt = 7'd1;

    t_out_item   results_due [$];
    int          n_fail = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int          free_run = 0;

    indexed_scatter_mac_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous run limit
    initial begin
        #5ms;
        $display("indexed_scatter_mac_top test failed");
        $finish;
    end

    // Expected entry for one request; updates the shadow table like the block does
    function automatic t_out_item predict_entry(t_in_item req);
        t_out_item         r;
        longint unsigned   loc, tr, col, slot;
        longint            tv, dv, prod, prior, sum;
        loc = req.location;
        tr = req.trend;
        col = req.column;
        r = '0;
        r.range_error = 1'b1;
        if (loc == 0 || loc > loc_cnt || loc > DEF_MAX_LOCATIONS || tr >= trend_cnt
                || col >= col_cnt)
            return r;
        slot = (loc - 1) + tr * loc_cnt + col * loc_cnt * trend_cnt;
        if (slot >= DEF_TABLE_ENTRIES)
            return r;
        r.range_error = 1'b0;
        prior = acc_table[slot];
        if (req.operation == OP_ACCUMULATE) begin
            tv = req.trend_value;
            dv = req.data_value;
            prod = tv * dv;
            sum = prior + prod;
            // signed overflow clamps to the Q32.32 bounds
            if (prior[63] == prod[63] && sum[63] != prior[63])
                sum = prior[63] ? ACC_MIN : ACC_MAX;
            acc_table[slot] = sum;
            r.entry_value = sum;
        end else begin
            r.entry_value = prior;
            acc_table[slot] = 0;
        end
        return r;
    endfunction

    // Mix of extremes, small values and full-range values
    function automatic logic signed [31:0] pick_q16();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    default: return Q_ONE;
                endcase
            end
            1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $signed($urandom);
        endcase
    endfunction

    // Write a count register over the config port, then read it back
    task automatic write_count(logic [1:0] reg_idx, int unsigned count);
        logic [31:0] mask;
        logic [31:0] got;
        case (reg_idx)
            REG_LOCATION_COUNT: mask = 32'h7FF;
            REG_TREND_COUNT:    mask = 32'h1F;
            default:            mask = 32'h7F;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= ($urandom & ~mask) | (count & mask);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (reg_idx)
            REG_LOCATION_COUNT: loc_cnt = 11'(count & mask);
            REG_TREND_COUNT:    trend_cnt = 5'(count & mask);
            default:            col_cnt = 7'(count & mask);
        endcase
        if (got !== (count & mask)) begin
            $error("count register %0d: expected %h, got %h", reg_idx, count & mask, got);
            n_fail++;
        end
    endtask

    // Offer one request, wait for it to be taken, queue its expected result
    task automatic send_req(t_in_item req, bit typed, logic signed [63:0] want_value,
                            bit want_err);
        t_out_item exp;
        int        gap;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        exp = predict_entry(req);
        if (typed) begin
            exp.entry_value = want_value;
            exp.range_error = want_err;
        end
        results_due.push_back(exp);
        // sender pacing: idle bursts between runs of back-to-back requests
        if (!calm) begin
            if (free_run > 0) begin
                free_run--;
            end else if ($urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 11);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                free_run = $urandom_range(1, 30);
            end
        end
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Result side: random stall bursts, one long hold on request, none when calm
    initial begin : result_side
        int left;
        bit stall;
        left = 0;
        stall = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                left = 79;
                stall = 1'b1;
            end else if (left > 0) begin
                left--;
            end else if (calm) begin
                stall = 1'b0;
            end else begin
                stall = ($urandom_range(0, 2) == 0);
                left = stall ? $urandom_range(0, 10) : $urandom_range(0, 39);
            end
            i_out_stall <= stall;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_out_item exp;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (results_due.size() == 0) begin
                $error("result with no request outstanding: entry_value %h", 
                       o_out_data.entry_value);
                n_fail++;
            end else begin
                exp = results_due.pop_front();
                if (o_out_data.entry_value !== exp.entry_value) begin
                    $error("entry_value: expected %h, got %h", exp.entry_value,
                           o_out_data.entry_value);
                    n_fail++;
                end
                if (o_out_data.range_error !== exp.range_error) begin
                    $error("range_error: expected %b, got %b", exp.range_error,
                           o_out_data.range_error);
                    n_fail++;
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_step     steps [$];
        t_step     s;
        t_in_item  req;
        int        phase_cfg [9][4];
        int        lo_max, tr_max, co_max;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;

        // location, trend, column counts and request count of each random phase
        phase_cfg = '{'{2, 2, 2, 185}, '{1024, 1, 4, 185}, '{5, 3, 7, 185},
                      '{1024, 16, 64, 185}, '{2047, 1, 2, 185}, '{1, 16, 64, 185},
                      '{64, 16, 4, 185}, '{3, 31, 127, 185}, '{1, 1, 1, 185}};

        // Directed table. Reset counts are 1/1/1, so only entry 0 is addressable at first.
        s = '{default: '0};
        s.req = '{operation: OP_READ, location: 11'd1, default: '0};
        s.want_value = 64'sd0; s.want_err = 1'b0;
        steps.push_back(s);
        // max * max three times: grows, then clamps at the top
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1, trend_value: Q_MAX,
                  data_value: Q_MAX, default: '0};
        s.want_value = 64'sh3FFF_FFFF_0000_0001;
        steps.push_back(s);
        s.want_value = 64'sh7FFF_FFFE_0000_0002;
        steps.push_back(s);
        s.want_value = ACC_MAX;
        steps.push_back(s);
        s.req.operation = OP_READ;
        s.want_value = ACC_MAX;
        steps.push_back(s);
        s.want_value = 64'sd0;
        steps.push_back(s);
        // min * max three times: clamps at the bottom
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1, trend_value: Q_MIN,
                  data_value: Q_MAX, default: '0};
        s.want_value = 64'shC000_0000_8000_0000;
        steps.push_back(s);
        s.want_value = 64'sh8000_0001_0000_0000;
        steps.push_back(s);
        s.want_value = ACC_MIN;
        steps.push_back(s);
        s.req.data_value = Q_MIN;
        s.want_value = 64'shC000_0000_0000_0000;
        steps.push_back(s);
        // out-of-range rejections
        s.want_value = 64'sd0; s.want_err = 1'b1;
        s.req = '{operation: OP_ACCUMULATE, location: 11'd0, trend_value: Q_ONE,
                  data_value: Q_ONE, default: '0};
        steps.push_back(s);
        s.req = '{operation: OP_READ, location: 11'd2, default: '0};
        steps.push_back(s);
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1, trend: 4'd1,
                  trend_value: Q_ONE, data_value: Q_ONE, default: '0};
        steps.push_back(s);
        s.req = '{operation: OP_READ, location: 11'd1, column: 6'd1, default: '0};
        steps.push_back(s);
        s.req = '{operation: OP_READ, location: 11'd2047, trend: 4'd15, column: 6'd63,
                  trend_value: Q_MIN, data_value: Q_MAX};
        steps.push_back(s);
        // rejected requests left the entry alone
        s.req = '{operation: OP_READ, location: 11'd1, default: '0};
        s.want_value = 64'shC000_0000_0000_0000; s.want_err = 1'b0;
        steps.push_back(s);
        // zero location count rejects everything
        s = '{default: '0};
        s.is_cfg = 1'b1; s.reg_idx = REG_LOCATION_COUNT; s.count = 0;
        steps.push_back(s);
        s = '{default: '0};
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1, trend_value: Q_ONE,
                  data_value: Q_ONE, default: '0};
        s.want_err = 1'b1;
        steps.push_back(s);
        // location count above the location limit
        s = '{default: '0};
        s.is_cfg = 1'b1; s.reg_idx = REG_LOCATION_COUNT; s.count = 2047;
        steps.push_back(s);
        s = '{default: '0};
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1025, trend_value: Q_ONE,
                  data_value: Q_ONE, default: '0};
        s.want_err = 1'b1;
        steps.push_back(s);
        s.req.location = 11'd1024;
        s.want_value = 64'sh0000_0001_0000_0000; s.want_err = 1'b0;
        steps.push_back(s);
        // full counts: address past the table end
        s = '{default: '0};
        s.is_cfg = 1'b1; s.reg_idx = REG_LOCATION_COUNT; s.count = 1024;
        steps.push_back(s);
        s.reg_idx = REG_TREND_COUNT; s.count = 16;
        steps.push_back(s);
        s.reg_idx = REG_COLUMN_COUNT; s.count = 64;
        steps.push_back(s);
        s = '{default: '0};
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1, column: 6'd1,
                  trend_value: Q_ONE, data_value: Q_ONE, default: '0};
        s.want_err = 1'b1;
        steps.push_back(s);
        // last entry of the table
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1024, trend: 4'd3,
                  trend_value: Q_NEG_ONE, data_value: Q_ONE, default: '0};
        s.want_value = 64'shFFFF_FFFF_0000_0000; s.want_err = 1'b0;
        steps.push_back(s);
        s.req.operation = OP_READ;
        steps.push_back(s);
        s.req = '{operation: OP_READ, location: 11'd1, trend: 4'd15, default: '0};
        s.want_value = 64'sd0; s.want_err = 1'b1;
        steps.push_back(s);
        // zero trend count, then zero column count
        s = '{default: '0};
        s.is_cfg = 1'b1; s.reg_idx = REG_TREND_COUNT; s.count = 0;
        steps.push_back(s);
        s = '{default: '0};
        s.req = '{operation: OP_READ, location: 11'd1, default: '0};
        s.want_err = 1'b1;
        steps.push_back(s);
        s = '{default: '0};
        s.is_cfg = 1'b1; s.reg_idx = REG_TREND_COUNT; s.count = 1;
        steps.push_back(s);
        s.reg_idx = REG_COLUMN_COUNT; s.count = 0;
        steps.push_back(s);
        s = '{default: '0};
        s.req = '{operation: OP_ACCUMULATE, location: 11'd1, trend_value: Q_MAX,
                  data_value: Q_MIN, default: '0};
        s.want_err = 1'b1;
        steps.push_back(s);

        // Reset; requests stall while the table clears
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k]) begin
            if (steps[k].is_cfg) begin
                drain();
                write_count(steps[k].reg_idx, steps[k].count);
            end else begin
                send_req(steps[k].req, 1'b1, steps[k].want_value, steps[k].want_err);
            end
        end

        // Random phases, each under its own count setting
        for (int p = 0; p < 9; p++) begin
            drain();
            write_count(REG_LOCATION_COUNT, phase_cfg[p][0]);
            write_count(REG_TREND_COUNT, phase_cfg[p][1]);
            write_count(REG_COLUMN_COUNT, phase_cfg[p][2]);
            if (p == 8)
                calm = 1'b1;
            lo_max = (loc_cnt > DEF_MAX_LOCATIONS) ? DEF_MAX_LOCATIONS : loc_cnt;
            tr_max = (trend_cnt > 16) ? 16 : trend_cnt;
            co_max = (col_cnt > 64) ? 64 : col_cnt;
            for (int n = 0; n < phase_cfg[p][3]; n++) begin
                // long hold on the result side fills the block and backs up requests
                if (p == 1 && n == 40)
                    hold_req = 1'b1;
                req.operation = ($urandom_range(0, 4) == 0) ? OP_READ : OP_ACCUMULATE;
                req.trend_value = pick_q16();
                req.data_value = pick_q16();
                if ($urandom_range(0, 7) != 0 && lo_max > 0 && tr_max > 0 && co_max > 0)
                begin
                    req.location = 11'($urandom_range(1, lo_max));
                    req.trend = 4'($urandom_range(0, tr_max - 1));
                    req.column = 6'($urandom_range(0, co_max - 1));
                end else begin
                    req.location = 11'($urandom);
                    req.trend = 4'($urandom);
                    req.column = 6'($urandom);
                end
                send_req(req, 1'b0, 64'sd0, 1'b0);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (n_fail == 0)
            $display("indexed_scatter_mac_top test passed");
        else
            $display("indexed_scatter_mac_top test failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ism_pkg.sv
hdl/ism_front.sv
hdl/ism_queue.sv
hdl/ism_back.sv
hdl/indexed_scatter_mac_top.sv
tb/sv/tb.sv
